@@ hdl/sbsm_pkg.sv @@
// Shared types and constants for the serial bank switch mapper.
package sbsm_pkg;

  localparam logic [2:0] SPACE_NONE    = 3'd0;
  localparam logic [2:0] SPACE_PRG_ROM = 3'd1;
  localparam logic [2:0] SPACE_PRG_RAM = 3'd2;
  localparam logic [2:0] SPACE_CHR_ROM = 3'd3;
  localparam logic [2:0] SPACE_CHR_RAM = 3'd4;

  localparam logic [1:0] CFG_BOARD_VARIANT = 2'd0;
  localparam logic [1:0] CFG_PRG_ROM_BANKS = 2'd1;
  localparam logic [1:0] CFG_CHR_ROM_BANKS = 2'd2;
  localparam logic [1:0] CFG_CHR_RAM_ONLY  = 2'd3;

  localparam logic [1:0] BOARD_OUTER = 2'd2;

  localparam logic [1:0] MAP_REG_CONTROL  = 2'd0;
  localparam logic [1:0] MAP_REG_CHR_LOW  = 2'd1;
  localparam logic [1:0] MAP_REG_CHR_HIGH = 2'd2;
  localparam logic [1:0] MAP_REG_PRG      = 2'd3;

  localparam logic [1:0] PRG_MODE_32K_EVEN = 2'd0;
  localparam logic [1:0] PRG_MODE_32K_ODD  = 2'd1;
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST = 2'd3;

  localparam logic [1:0] MIRROR_ONE_SCREEN = 2'd0;
  localparam logic [1:0] MIRROR_VERTICAL   = 2'd1;
  localparam logic [1:0] MIRROR_HORIZONTAL = 2'd2;

  localparam logic [1:0] MAP_CTRL_VERTICAL = 2'd2;

  localparam logic [4:0] SHIFT_EMPTY   = 5'h10;
  localparam logic [4:0] CONTROL_RESET = 5'h0c;

  localparam logic [19:0] OUTER_HALF_SIZE = 20'd262144;
  localparam logic [19:0] PRG_BANK_SIZE   = 20'h04000;

  typedef struct packed {
    logic [1:0] board_variant;
    logic [5:0] prg_rom_banks;
    logic [5:0] chr_rom_banks;
    logic       chr_ram_only;
  } cfg_t;

  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [3:0] prg_bank;
    logic [1:0] ram_bank;
    logic       outer_half;
    logic [1:0] mirror;
  } map_state_t;

  typedef struct packed {
    logic [2:0]  space;
    logic [18:0] address;
    logic        is_write;
    logic [7:0]  value;
    logic        error;
  } result_t;

endpackage

@@ hdl/sbsm_regs.sv @@
// Mapper register file with the five-bit serial load shift register.
module sbsm_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   update,
  input  logic                   command,
  input  logic [15:0]            bus_address,
  input  logic [7:0]             write_data,
  input  logic [1:0]             board_variant,
  output sbsm_pkg::map_state_t   state,
  output logic [1:0]             mirror_next
);

  sbsm_pkg::map_state_t state_next;
  logic [4:0] shift;
  logic [4:0] shift_next;
  logic [4:0] load_value;
  logic       outer_board;

  assign outer_board = (board_variant == sbsm_pkg::BOARD_OUTER);
  assign load_value  = {write_data[0], shift[4:1]};
  assign mirror_next = state_next.mirror;

  always_comb begin
    state_next = state;
    shift_next = shift;
    if (update && command && bus_address[15]) begin
      if (write_data[7]) begin
        shift_next = sbsm_pkg::SHIFT_EMPTY;
        state_next.control = state.control | sbsm_pkg::CONTROL_RESET;
      end else if (!shift[0]) begin
        shift_next = load_value;
      end else begin
        shift_next = sbsm_pkg::SHIFT_EMPTY;
        unique case (bus_address[14:13])
          sbsm_pkg::MAP_REG_CONTROL: begin
            state_next.control = load_value;
            if (load_value[1:0] == sbsm_pkg::MAP_CTRL_VERTICAL) begin
              state_next.mirror = sbsm_pkg::MIRROR_VERTICAL;
            end else if (load_value[1]) begin
              state_next.mirror = sbsm_pkg::MIRROR_HORIZONTAL;
            end else begin
              state_next.mirror = sbsm_pkg::MIRROR_ONE_SCREEN;
            end
          end
          sbsm_pkg::MAP_REG_CHR_LOW: begin
            state_next.chr_low = load_value;
            if (outer_board) begin
              state_next.ram_bank   = load_value[3:2];
              state_next.outer_half = load_value[4];
            end
          end
          sbsm_pkg::MAP_REG_CHR_HIGH: begin
            state_next.chr_high = load_value;
            if (outer_board && state.control[4]) begin
              state_next.ram_bank   = load_value[3:2];
              state_next.outer_half = load_value[4];
            end
          end
          sbsm_pkg::MAP_REG_PRG: begin
            state_next.prg_bank = load_value[3:0];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift            <= sbsm_pkg::SHIFT_EMPTY;
      state.control    <= sbsm_pkg::CONTROL_RESET;
      state.chr_low    <= '0;
      state.chr_high   <= '0;
      state.prg_bank   <= '0;
      state.ram_bank   <= '0;
      state.outer_half <= 1'b0;
      state.mirror     <= sbsm_pkg::MIRROR_ONE_SCREEN;
    end else begin
      shift <= shift_next;
      state <= state_next;
    end
  end

endmodule

@@ hdl/sbsm_decode.sv @@
// Address translation of one bus access into a target space and offset.
module sbsm_decode #(
  parameter int PRG_ADDR_WIDTH = 19
) (
  input  logic                 command,
  input  logic [15:0]          bus_address,
  input  logic [7:0]           write_data,
  input  sbsm_pkg::cfg_t       cfg,
  input  sbsm_pkg::map_state_t state,
  output sbsm_pkg::result_t    result
);

  localparam logic [19:0] PrgMask = 20'((21'd1 << PRG_ADDR_WIDTH) - 21'd1);

  logic        outer_board;
  logic        chr_4k;
  logic [19:0] prg_size;
  logic [19:0] prg_space;
  logic [19:0] prg_last;
  logic [19:0] prg_start;
  logic [19:0] prg_base;
  logic [19:0] prg_offset;
  logic [19:0] prg_addr;
  logic [19:0] bank_single;
  logic [19:0] bank_pair;
  logic [17:0] chr_addr;
  logic [17:0] chr_size;
  logic [14:0] ram_addr;

  always_comb begin
    outer_board = (cfg.board_variant == sbsm_pkg::BOARD_OUTER);
    chr_4k      = state.control[4];
    prg_size    = {cfg.prg_rom_banks, 14'd0};
    prg_space   = outer_board ? sbsm_pkg::OUTER_HALF_SIZE : prg_size;
    prg_last    = (prg_space >= sbsm_pkg::PRG_BANK_SIZE) ?
                  prg_space - sbsm_pkg::PRG_BANK_SIZE : '0;
    prg_start   = (outer_board && state.outer_half) ? sbsm_pkg::OUTER_HALF_SIZE : '0;
    bank_single = {2'd0, state.prg_bank, 14'd0};
    bank_pair   = {2'd0, state.prg_bank[3:1], 1'b0, 14'd0};
    prg_offset  = {6'd0, bus_address[13:0]};

    case (state.control[3:2]) inside
      sbsm_pkg::PRG_MODE_32K_EVEN, sbsm_pkg::PRG_MODE_32K_ODD: begin
        prg_base   = bank_pair;
        prg_offset = {5'd0, bus_address[14:0]};
      end
      sbsm_pkg::PRG_MODE_FIX_FIRST: begin
        prg_base = bus_address[14] ? bank_single : '0;
      end
      default: begin
        prg_base = bus_address[14] ? prg_last : bank_single;
      end
    endcase
    prg_addr = prg_start + prg_base + prg_offset;

    if (chr_4k) begin
      if (bus_address[12]) begin
        chr_addr = {1'b0, state.chr_high, 12'd0} + {6'd0, bus_address[11:0]};
      end else begin
        chr_addr = {1'b0, state.chr_low, 12'd0} + {6'd0, bus_address[11:0]};
      end
    end else begin
      chr_addr = {1'b0, state.chr_low[4:1], 1'b0, 12'd0} + {5'd0, bus_address[12:0]};
    end
    chr_size = {cfg.chr_rom_banks, 12'd0};

    if (chr_4k) begin
      ram_addr = {1'b0, state.ram_bank, 12'd0} + {2'd0, bus_address[12:0]};
    end else begin
      ram_addr = {state.ram_bank, 13'd0} + {2'd0, bus_address[12:0]};
    end

    result = '0;
    if (bus_address[15]) begin
      if (!command) begin
        result.space   = sbsm_pkg::SPACE_PRG_ROM;
        result.address = 19'(prg_addr & PrgMask);
        result.error   = (prg_addr >= prg_size);
      end
    end else if (bus_address[15:13] == 3'b011) begin
      result.space    = sbsm_pkg::SPACE_PRG_RAM;
      result.address  = {4'd0, ram_addr};
      result.is_write = command;
    end else if (bus_address[15:13] == 3'b000) begin
      if (command || cfg.chr_ram_only) begin
        result.space    = sbsm_pkg::SPACE_CHR_RAM;
        result.address  = {6'd0, bus_address[12:0]};
        result.is_write = command;
      end else begin
        result.space   = sbsm_pkg::SPACE_CHR_ROM;
        result.address = {1'b0, chr_addr};
        result.error   = (chr_addr >= chr_size);
      end
    end
    result.value = result.is_write ? write_data : 8'd0;
  end

endmodule

@@ hdl/serial_bank_switch_mapper.sv @@
// Top level of the serial bank switch mapper address decoder.
//
// Each bus access (command, bus_address, write_data) is a transfer on the
// input channel when in_valid is high and in_stall is low. The access is held
// in an input register, decoded in the next cycle and its result lands in the
// output register, which raises out_valid when that register is loaded.
// One access is taken in every cycle; the only limit is the output register,
// and in_stall is high exactly while a result waits with out_stall high.
// Writes at 0x8000 and above load the serial shift register and update the
// mapper registers when the result register is loaded, so results leave in
// the order the accesses came in. mirror_mode shows the mirroring after the
// access. A stalled result holds its value until it is transferred.
// The configuration port takes a write in every cycle (cfg_ready is always
// high) and should only be used while no access is in flight.
// Synchronous reset empties both registers, restores the mapper registers
// and loads the default configuration.
module serial_bank_switch_mapper #(
  parameter int PRG_ADDR_WIDTH = 19
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  target_space,
  output logic [18:0] target_address,
  output logic        access_is_write,
  output logic [7:0]  write_value,
  output logic [1:0]  mirror_mode,
  output logic        range_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  sbsm_pkg::cfg_t       cfg;
  sbsm_pkg::map_state_t state;
  sbsm_pkg::result_t    result;
  logic                 advance;
  logic                 hold_valid;
  logic                 hold_command;
  logic [15:0]          hold_address;
  logic [7:0]           hold_data;
  logic [1:0]           mirror_next;

  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.board_variant <= 2'd0;
      cfg.prg_rom_banks <= 6'd2;
      cfg.chr_rom_banks <= 6'd0;
      cfg.chr_ram_only  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sbsm_pkg::CFG_BOARD_VARIANT: cfg.board_variant <= cfg_data[1:0];
        sbsm_pkg::CFG_PRG_ROM_BANKS: cfg.prg_rom_banks <= cfg_data;
        sbsm_pkg::CFG_CHR_ROM_BANKS: cfg.chr_rom_banks <= cfg_data;
        sbsm_pkg::CFG_CHR_RAM_ONLY:  cfg.chr_ram_only  <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (advance) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hold_command <= command;
      hold_address <= bus_address;
      hold_data    <= write_data;
    end
  end

  sbsm_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .update        (advance && hold_valid),
    .command       (hold_command),
    .bus_address   (hold_address),
    .write_data    (hold_data),
    .board_variant (cfg.board_variant),
    .state         (state),
    .mirror_next   (mirror_next)
  );

  sbsm_decode #(
    .PRG_ADDR_WIDTH (PRG_ADDR_WIDTH)
  ) u_decode (
    .command     (hold_command),
    .bus_address (hold_address),
    .write_data  (hold_data),
    .cfg         (cfg),
    .state       (state),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      target_space    <= result.space;
      target_address  <= result.address;
      access_is_write <= result.is_write;
      write_value     <= result.value;
      range_error     <= result.error;
      mirror_mode     <= mirror_next;
    end
  end

endmodule

@@ hdl/sbsm_checker.sv @@
// Port-level checks for the serial bank switch mapper, bound to the top level.
module sbsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  target_space,
  input logic [18:0] target_address,
  input logic        access_is_write,
  input logic [7:0]  write_value,
  input logic        range_error
);

  a_stall_only_from_output: assert property (
    @(posedge clk) disable iff (rst) !out_stall |-> !in_stall
  ) else $error("Input stalled while the output side was not stalling.");

  a_result_held: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(target_address) &&
                               $stable(target_space)
  ) else $error("A stalled result changed before its transfer.");

  a_none_is_empty: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && target_space == sbsm_pkg::SPACE_NONE |->
      target_address == 19'd0 && !access_is_write
  ) else $error("A result with no target carried an address or a write.");

  a_error_only_rom: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && range_error |->
      target_space == sbsm_pkg::SPACE_PRG_ROM || target_space == sbsm_pkg::SPACE_CHR_ROM
  ) else $error("A range error was flagged outside a ROM space.");

  a_write_value_zero: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && !access_is_write |-> write_value == 8'd0
  ) else $error("A non-write result carried a write value.");

endmodule

bind serial_bank_switch_mapper sbsm_checker u_sbsm_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .target_space    (target_space),
  .target_address  (target_address),
  .access_is_write (access_is_write),
  .write_value     (write_value),
  .range_error     (range_error)
);
